FILE: hw/rtl/rsng_pkg.sv
// ----------------------------------------------------------------------------
// rsng_pkg
// Shared constants, configuration and control types of the rotary scroll
// noise gate.
// ----------------------------------------------------------------------------
`default_nettype none

package rsng_pkg;

   // Field widths
   localparam int unsigned ANGLE_W   = 12;
   localparam int unsigned DELTA_W   = ANGLE_W + 1;
   localparam int unsigned LIMIT_W   = 12;
   localparam int unsigned MARGIN_W  = 12;
   localparam int unsigned SPEED_W   = 8;
   localparam int unsigned AMOUNT_W  = 8;

   // Defaults of the top-level parameters
   localparam int unsigned PASS_LENGTH_DEF = 99;
   localparam int unsigned ANGLE_BITS_DEF  = 12;

   localparam int unsigned STEP_LIMIT = 127;

   // Register reset values
   localparam logic [LIMIT_W-1:0]  JUMP_LIMIT_RST    = 12'd1000;
   localparam logic [MARGIN_W-1:0] NOISE_MARGIN_RST  = 12'd8;
   localparam logic [SPEED_W-1:0]  SPEED_DIVISOR_RST = 8'd3;

   // Register file: word index taken from paddr[3:2]
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [1:0]  REG_JUMP_LIMIT    = 2'd0;
   localparam logic [1:0]  REG_NOISE_MARGIN  = 2'd1;
   localparam logic [1:0]  REG_SPEED_DIVISOR = 2'd2;

   typedef struct packed {
      logic [LIMIT_W-1:0]  jump_limit;
      logic [MARGIN_W-1:0] noise_margin;
      logic [SPEED_W-1:0]  speed_divisor;
   } rsng_cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;       // latch the sample and update the pass
      logic avg_start;     // start |sum| / count
      logic check;         // apply the gate and resync the angle
      logic step_start;    // start |delta| / divisor
      logic take_step;     // stage the scaled, clamped step
      logic clear_result;  // stage an empty result
      logic publish;       // move the staged result to the output
   } rsng_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic link;
      logic div_done;
      logic scroll_go;
      logic out_free;
   } rsng_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/rsng_div.sv
// ----------------------------------------------------------------------------
// rsng_div
// Restoring unsigned divider, one quotient bit per cycle. The numerator is
// consumed from its top bit; after n steps the low n bits hold the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module rsng_div #(
   parameter int unsigned NUM_W = 20,
   parameter int unsigned DEN_W = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [NUM_W-1:0]            numerator,
   input  wire logic [DEN_W-1:0]            denominator,
   input  wire logic [$clog2(NUM_W+1)-1:0]  steps,
   output logic      [NUM_W-1:0]            quotient,
   output logic                             done
);

   localparam int unsigned IT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [IT_W-1:0]  count_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0]   acc;
   logic [DEN_W+1:0] diff;
   logic             neg;

   assign acc  = {rem_ff, num_ff[NUM_W-1]};
   assign diff = {1'b0, acc} - {2'b00, den_ff};
   assign neg  = diff[DEN_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= steps;
         end else if (busy_ff) begin
            count_ff <= count_ff - IT_W'(1);
            if (count_ff == IT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= numerator;
         rem_ff <= '0;
         den_ff <= denominator;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], ~neg};
         rem_ff <= neg ? acc[DEN_W-1:0] : diff[DEN_W-1:0];
      end
   end

   assign quotient = num_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rsng_dp.sv
// ----------------------------------------------------------------------------
// rsng_dp
// Datapath: angle delta, pass sum and count, gate decision, step scaling and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsng_dp
   import rsng_pkg::*;
#(
   parameter int unsigned PASS_LENGTH = PASS_LENGTH_DEF,
   parameter int unsigned ANGLE_BITS  = ANGLE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rsng_cfg_type          cfg,
   input  wire rsng_cmd_type          cmd,
   output rsng_status_type            status,
   input  wire logic [ANGLE_W-1:0]    angle,
   input  wire logic                  link_up,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic signed [AMOUNT_W-1:0] rsp_tdata,
   output logic                       rsp_tuser
);

   localparam int unsigned CNT_W  = $clog2(PASS_LENGTH + 1);
   localparam int unsigned MAG_W  = CNT_W + ANGLE_W;
   localparam int unsigned SUM_W  = MAG_W + 1;
   localparam int unsigned DEN_W  = (CNT_W > SPEED_W) ? CNT_W : SPEED_W;
   localparam int unsigned IT_W   = $clog2(MAG_W + 1);
   localparam int unsigned MASK_BITS = (ANGLE_BITS < ANGLE_W) ? ANGLE_BITS : ANGLE_W;
   localparam logic [ANGLE_W-1:0] ANGLE_MASK = {ANGLE_W{1'b1}} >> (ANGLE_W - MASK_BITS);
   localparam logic [CNT_W-1:0]   PASS_LAST  = CNT_W'(PASS_LENGTH);
   localparam logic [ANGLE_W-1:0] STEP_MAX   = ANGLE_W'(STEP_LIMIT);

   logic [ANGLE_W-1:0]        last_angle_ff;
   logic [ANGLE_W-1:0]        cur_ff;
   logic                      link_ff;
   logic [CNT_W-1:0]          count_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic                      delta_neg_ff;
   logic [ANGLE_W-1:0]        dmag_ff;
   logic                      res_valid_ff;
   logic signed [AMOUNT_W-1:0] res_amount_ff;
   logic                      rsp_tvalid_ff;
   logic signed [AMOUNT_W-1:0] rsp_tdata_ff;
   logic                      rsp_tuser_ff;

   logic [ANGLE_W-1:0]        cur;
   logic signed [DELTA_W-1:0] delta;
   logic [DELTA_W-1:0]        delta_abs;
   logic signed [SUM_W-1:0]   sum_base;
   logic signed [SUM_W-1:0]   sum_in;
   logic [SUM_W-1:0]          sum_abs;
   logic                      restart;

   logic [MAG_W:0]            floor_level;
   logic                      scroll_go;
   logic                      jump;

   logic [MAG_W-1:0]          div_num;
   logic [DEN_W-1:0]          div_den;
   logic [IT_W-1:0]           div_steps;
   logic [MAG_W-1:0]          quotient;
   logic                      div_done;
   logic [SPEED_W-1:0]        speed;
   logic [ANGLE_W-1:0]        step_q;
   logic [AMOUNT_W-1:0]       step_mag;

   // ---- sample capture and pass accumulation ----
   assign cur       = angle & ANGLE_MASK;
   assign delta     = $signed({1'b0, last_angle_ff}) - $signed({1'b0, cur});
   assign delta_abs = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);
   assign restart   = (count_ff >= PASS_LAST);
   assign sum_base  = restart ? '0 : sum_ff;
   assign sum_in    = sum_base + SUM_W'(delta);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_angle_ff <= '0;
         count_ff      <= '0;
         sum_ff        <= '0;
      end else begin
         if (cmd.capture) begin
            sum_ff   <= sum_in;
            count_ff <= (restart ? '0 : count_ff) + CNT_W'(1);
         end
         if (cmd.check && (scroll_go || jump)) begin
            last_angle_ff <= cur_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_ff       <= cur;
         link_ff      <= link_up;
         delta_neg_ff <= delta[DELTA_W-1];
         dmag_ff      <= delta_abs[ANGLE_W-1:0];
      end
   end

   // ---- gate: the quotient holds |average| while the check runs ----
   assign floor_level = {1'b0, quotient} + (MAG_W+1)'(cfg.noise_margin);
   assign scroll_go   = ({{(MAG_W+1-ANGLE_W){1'b0}}, dmag_ff} > floor_level) &&
                        (dmag_ff < cfg.jump_limit);
   assign jump        = dmag_ff > cfg.jump_limit;

   // ---- shared divider ----
   assign sum_abs = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign speed   = (cfg.speed_divisor == '0) ? SPEED_W'(1) : cfg.speed_divisor;

   always_comb begin
      if (cmd.step_start) begin
         // Align |delta| with the top so that ANGLE_W steps suffice.
         div_num   = {dmag_ff, {(MAG_W-ANGLE_W){1'b0}}};
         div_den   = DEN_W'(speed);
         div_steps = IT_W'(ANGLE_W);
      end else begin
         div_num   = sum_abs[MAG_W-1:0];
         div_den   = DEN_W'(count_ff);
         div_steps = IT_W'(MAG_W);
      end
   end

   rsng_div #(
      .NUM_W (MAG_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.avg_start || cmd.step_start),
      .numerator   (div_num),
      .denominator (div_den),
      .steps       (div_steps),
      .quotient    (quotient),
      .done        (div_done)
   );

   // ---- step clamp and result staging ----
   assign step_q   = quotient[ANGLE_W-1:0];
   assign step_mag = (step_q > STEP_MAX) ? AMOUNT_W'(STEP_LIMIT) : AMOUNT_W'(step_q);

   always_ff @(posedge clock) begin
      if (cmd.take_step) begin
         res_valid_ff  <= 1'b1;
         res_amount_ff <= delta_neg_ff ? $signed(-step_mag) : $signed(step_mag);
      end else if (cmd.clear_result) begin
         res_valid_ff  <= 1'b0;
         res_amount_ff <= '0;
      end
   end

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_tdata_ff <= res_amount_ff;
         rsp_tuser_ff <= res_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   assign status.link      = link_ff;
   assign status.div_done  = div_done;
   assign status.scroll_go = scroll_go;
   assign status.out_free  = !rsp_tvalid_ff || rsp_tready;

`ifndef NO_ASSERTIONS
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= PASS_LAST)
      else $error("pass count beyond pass length");

   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("non-zero amount on a transaction without a scroll step");

   a_clamped : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata != $signed({1'b1, {(AMOUNT_W-1){1'b0}}}))
      else $error("scroll amount escaped the clamp");

   a_angle_hold : assert property (@(posedge clock) disable iff (reset)
      !cmd.check |=> $stable(last_angle_ff))
      else $error("accepted angle changed outside the gate check");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/rsng_ctrl.sv
// ----------------------------------------------------------------------------
// rsng_ctrl
// Sequencer: accepts one sample, runs the needed average and step divisions
// on the shared divider and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsng_ctrl
   import rsng_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire rsng_status_type status,
   output rsng_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_CHECK,
      ST_STEP_WAIT,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_AVG_GO;
            end
         end
         ST_AVG_GO: begin
            // With the link down the sample only feeds the pass sum.
            if (status.link) begin
               cmd.avg_start = 1'b1;
               state_in      = ST_AVG_WAIT;
            end else begin
               cmd.clear_result = 1'b1;
               state_in         = ST_DONE;
            end
         end
         ST_AVG_WAIT: begin
            if (status.div_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (status.scroll_go) begin
               cmd.step_start = 1'b1;
               state_in       = ST_STEP_WAIT;
            end else begin
               cmd.clear_result = 1'b1;
               state_in         = ST_DONE;
            end
         end
         ST_STEP_WAIT: begin
            if (status.div_done) begin
               cmd.take_step = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

FILE: hw/rtl/rotary_scroll_noise_gate_core.sv
// ----------------------------------------------------------------------------
// rotary_scroll_noise_gate_core
// Turns encoder angle samples into gated, scaled scroll steps.
// ----------------------------------------------------------------------------
// Each request transaction carries one angle and the link-up flag and yields
// exactly one response transaction. One sample is processed at a time; the
// cost is set by the shared divider, which produces one quotient bit per
// cycle. With the link down no division runs; otherwise the average division
// runs over MAG_W = clog2(PASS_LENGTH+1) + 12 (19 by default) quotient bits,
// and a step division follows when a scroll step is issued. The response may
// also wait for rsp_tready. A new request is taken as soon as the previous
// result has entered the output register. Registers: jump_limit at 0x0,
// noise_margin at 0x4, speed_divisor at 0x8 (0 behaves as 1); write them
// only while the block is idle.
`default_nettype none

module rotary_scroll_noise_gate_core
   import rsng_pkg::*;
#(
   parameter int unsigned PASS_LENGTH = PASS_LENGTH_DEF,
   parameter int unsigned ANGLE_BITS  = ANGLE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,   // [11:0] angle, [15:12] zero
   input  wire logic                  req_tuser,   // [0] link_up
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic signed [AMOUNT_W-1:0] rsp_tdata,   // [7:0] scroll_amount
   output logic                       rsp_tuser,   // [0] scroll_valid
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   rsng_cfg_type    cfg_ff;
   rsng_cmd_type    cmd;
   rsng_status_type status;
   logic            csr_write;
   logic [1:0]      csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.jump_limit    <= JUMP_LIMIT_RST;
         cfg_ff.noise_margin  <= NOISE_MARGIN_RST;
         cfg_ff.speed_divisor <= SPEED_DIVISOR_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_JUMP_LIMIT:    cfg_ff.jump_limit    <= csr_pwdata[LIMIT_W-1:0];
            REG_NOISE_MARGIN:  cfg_ff.noise_margin  <= csr_pwdata[MARGIN_W-1:0];
            REG_SPEED_DIVISOR: cfg_ff.speed_divisor <= csr_pwdata[SPEED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_JUMP_LIMIT:    csr_prdata = CSR_DATA_W'(cfg_ff.jump_limit);
         REG_NOISE_MARGIN:  csr_prdata = CSR_DATA_W'(cfg_ff.noise_margin);
         REG_SPEED_DIVISOR: csr_prdata = CSR_DATA_W'(cfg_ff.speed_divisor);
         default:           csr_prdata = '0;
      endcase
   end

   rsng_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rsng_dp #(
      .PASS_LENGTH (PASS_LENGTH),
      .ANGLE_BITS  (ANGLE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .status     (status),
      .angle      (req_tdata[ANGLE_W-1:0]),
      .link_up    (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rotary scroll noise gate core.
// ----------------------------------------------------------------------------
// Angle samples go in over the request stream and gated scroll steps come
// back over the response stream. A tracker class keeps its own copy of the
// pass statistics, the accepted angle and the registers. It predicts one step
// for every accepted sample and checks each response against the oldest
// prediction. A short directed run comes first, then random runs under
// several register settings and idle patterns.

typedef struct packed {
   logic       valid;
   logic [7:0] amount;
} scroll_step_type;

class scroll_gate_tracker;
   logic [11:0]     jump_limit;
   logic [11:0]     noise_margin;
   logic [7:0]      speed_divisor;
   logic [11:0]     held_angle;
   int              pass_count;
   int              pass_sum;
   scroll_step_type awaited_steps[$];
   int              failures;

   function new();
      jump_limit    = rsng_pkg::JUMP_LIMIT_RST;
      noise_margin  = rsng_pkg::NOISE_MARGIN_RST;
      speed_divisor = rsng_pkg::SPEED_DIVISOR_RST;
      held_angle    = '0;
      pass_count    = 0;
      pass_sum      = 0;
      failures      = 0;
   endfunction

   function void write_register(logic [1:0] index, logic [31:0] value);
      case (index)
         rsng_pkg::REG_JUMP_LIMIT:    jump_limit = value[11:0];
         rsng_pkg::REG_NOISE_MARGIN:  noise_margin = value[11:0];
         rsng_pkg::REG_SPEED_DIVISOR: speed_divisor = value[7:0];
         default: ;
      endcase
   endfunction

   // Works out the step that one accepted sample must produce.
   function void note_sample(logic [11:0] angle, logic link);
      int              delta;
      int              dmag;
      int              average;
      int              floor_level;
      int              divisor;
      int              step;
      scroll_step_type result;
      delta = int'(held_angle) - int'(angle);
      dmag = (delta < 0) ? -delta : delta;
      step = 0;
      result.valid = 1'b0;
      if (pass_count >= rsng_pkg::PASS_LENGTH_DEF) begin
         pass_count = 0;
         pass_sum = 0;
      end
      pass_sum += delta;
      pass_count++;
      if (link) begin
         average = pass_sum / pass_count;
         floor_level = ((average < 0) ? -average : average) + int'(noise_margin);
         if (dmag < int'(jump_limit) && dmag > floor_level) begin
            divisor = (speed_divisor == 8'd0) ? 1 : int'(speed_divisor);
            step = delta / divisor;
            if (step > 127) step = 127;
            if (step < -127) step = -127;
            result.valid = 1'b1;
            held_angle = angle;
         end else if (dmag > int'(jump_limit)) begin
            held_angle = angle;
         end
      end
      result.amount = step[7:0];
      awaited_steps.push_back(result);
   endfunction

   function void check_step(logic valid, logic [7:0] amount);
      scroll_step_type want;
      if (awaited_steps.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected response transaction: valid %0b amount %0d",
                     valid, $signed(amount));
         return;
      end
      want = awaited_steps.pop_front();
      if (valid !== want.valid || amount !== want.amount) begin
         failures++;
         if (failures <= 10)
            $display({"wrong scroll step: expected valid %0b amount %0d, ",
                      "got valid %0b amount %0d"},
                     want.valid, $signed(want.amount), valid, $signed(amount));
      end
   endfunction
endclass

module testbench;
   import rsng_pkg::*;

   localparam int         STALL_LIMIT   = 4000;
   localparam int         SETTLE_CYCLES = 60;
   localparam logic [1:0] REG_UNUSED    = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;   // [11:0] angle, [15:12] zero
   logic                  req_tuser;   // [0] link_up
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [AMOUNT_W-1:0]   rsp_tdata;   // [7:0] scroll_amount
   logic                  rsp_tuser;   // [0] scroll_valid
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    tx_idle_pct;
   int                    rx_idle_pct;
   int                    quiet_cycles;
   scroll_gate_tracker    tracker = new();

   rotary_scroll_noise_gate_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_step(rsp_tuser, rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("rotary_scroll_noise_gate_core: mismatch");
            $finish;
         end
      end
   end

   // Valid is only lowered while idling before the next sample, so a
   // back-to-back sample never sees valid dropped and raised in one step.
   task automatic send_sample(input logic [11:0] angle, input logic link);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, angle};
      req_tuser <= link;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_sample(angle, link);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tracker.write_register(index, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure_gate(input logic [11:0] limit, input logic [11:0] margin,
                                 input logic [7:0] divisor);
      write_csr(REG_JUMP_LIMIT, {20'd0, limit});
      write_csr(REG_NOISE_MARGIN, {20'd0, margin});
      write_csr(REG_SPEED_DIVISOR, {24'd0, divisor});
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (tracker.awaited_steps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Mostly plausible turns from the accepted angle, so that the gate and
   // the clamp are exercised, with link drops and wild angles mixed in.
   task automatic run_random(input int count);
      int          pick;
      int          span;
      int          turn;
      logic [11:0] angle;
      logic        link;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         span = int'(tracker.jump_limit) + 16;
         if (span > 4095) span = 4095;
         if (pick < 72) begin
            turn = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span)
                                               : $urandom_range(0, 64);
            if ($urandom_range(0, 1) == 1) turn = -turn;
            angle = tracker.held_angle - turn[11:0];
            link = 1'b1;
         end else if (pick < 84) begin
            angle = 12'($urandom);
            link = 1'b0;
         end else begin
            angle = 12'($urandom);
            link = 1'b1;
         end
         send_sample(angle, link);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      rsp_tready <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      tx_idle_pct = 18;
      rx_idle_pct = 48;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: still input, small turns above and below the noise
      // floor, a turn exactly at the jump limit, a link drop and a jump.
      send_sample(12'd0, 1'b1);
      send_sample(12'd40, 1'b1);
      send_sample(12'd20, 1'b1);
      send_sample(12'd22, 1'b1);
      send_sample(12'd1020, 1'b1);
      send_sample(12'd1021, 1'b0);
      send_sample(12'd1021, 1'b1);
      wait_for_drain();

      // Widest gate and unit divisor: steps clamp in both directions, and a
      // full-scale turn equal to the limit neither scrolls nor resyncs.
      configure_gate(12'd4095, 12'd0, 8'd1);
      send_sample(12'd121, 1'b1);
      send_sample(12'd1021, 1'b1);
      send_sample(12'd0, 1'b1);
      send_sample(12'd4095, 1'b1);
      wait_for_drain();

      // A zero divisor behaves as one; a write past the last register is
      // dropped, and upper data bits are ignored.
      write_csr(REG_SPEED_DIVISOR, 32'd0);
      write_csr(REG_UNUSED, 32'hFFFF_FFFF);
      send_sample(12'd3895, 1'b1);
      send_sample(12'd3995, 1'b1);
      wait_for_drain();
      write_csr(REG_JUMP_LIMIT, 32'hABCD_E3E8);
      write_csr(REG_NOISE_MARGIN, 32'hFFFF_FFFF);
      write_csr(REG_SPEED_DIVISOR, 32'h1234_56FF);
      send_sample(12'd3900, 1'b1);
      send_sample(12'd0, 1'b1);
      wait_for_drain();
      configure_gate(12'd0, 12'd4095, 8'd255);
      send_sample(12'd4095, 1'b1);
      send_sample(12'd0, 1'b1);
      send_sample(12'd0, 1'b1);
      wait_for_drain();

      configure_gate(12'd1000, 12'd8, 8'd3);
      run_random(300);
      wait_for_drain();

      tx_idle_pct = 48;
      rx_idle_pct = 18;
      configure_gate(12'($urandom_range(100, 2000)), 12'($urandom_range(0, 40)),
                     8'($urandom_range(1, 16)));
      run_random(300);
      wait_for_drain();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      configure_gate(12'd4095, 12'd0, 8'd1);
      run_random(275);
      wait_for_drain();
      configure_gate(12'($urandom_range(300, 1500)), 12'($urandom_range(0, 20)), 8'd255);
      run_random(275);

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.awaited_steps.size() == 0) begin
         $display("rotary_scroll_noise_gate_core: match");
      end else begin
         $display("rotary_scroll_noise_gate_core: mismatch");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/rsng_pkg.sv
hw/rtl/rsng_div.sv
hw/rtl/rsng_dp.sv
hw/rtl/rsng_ctrl.sv
hw/rtl/rotary_scroll_noise_gate_core.sv
sim/testbench.sv
